// ===== rtl/uph_pkg.sv =====
// Package for the port-to-handler table: sizes, command and status codes,
// and the item structs of both channels. No dependencies.
package uph_pkg;

  // Table geometry.
  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);

  // Field widths fixed by the item format.
  localparam int CMD_W  = 2;
  localparam int PORT_W = 16;
  localparam int HID_W  = 8;
  localparam int STAT_W = 2;
  localparam int SLOT_W = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_OPEN   = 2'd1,
    CMD_CLOSE  = 2'd2
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_UNREACH = 2'd2
  } status_e;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [PORT_W-1:0] port;
    logic [HID_W-1:0]  handler_id;
  } uph_in_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot;
    logic [HID_W-1:0]  handler_out;
  } uph_out_t;

endpackage

// ===== rtl/udp_port_handler_table.sv =====
// Port-to-handler table: port tags and valid bits in flops, handler ids in a
// synchronous RAM with a registered read.
// Depends on uph_pkg.
//
//   Channel | Signals                               | Direction
//   --------+---------------------------------------+----------
//   in      | in_valid_i, in_ready_o, in_data_i     | into block
//   out     | out_valid_o, out_ready_i, out_data_o  | out of block
//
// Each item is captured first; in the execute state its port is compared
// against all tags, tags and valid bits are updated, the handler RAM accessed.
// The result sits in an output register; the next item is taken right after.
// If a result is not taken, the following item waits in the execute state.
// Reset clears all tags to port zero and all valid bits; the handler RAM is
// not cleared, since an entry only becomes valid when its handler is written.
module udp_port_handler_table
  import uph_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  uph_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output uph_out_t out_data_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                    state_q, state_d;
  uph_in_t                 item_q;
  logic [PORT_W-1:0]       tag_q [ENTRIES];
  logic [ENTRIES-1:0]      valid_q;
  logic [HID_W-1:0]        hmem [ENTRIES];
  logic [HID_W-1:0]        rdata_q;

  logic                    out_valid_q;
  logic [STAT_W-1:0]       status_q, status_d;
  logic [SLOT_W-1:0]       slot_q, slot_d;
  logic                    deliver_q, deliver_d;

  logic [ENTRIES-1:0]      match;
  logic                    any_match, any_free;
  logic [IDX_W-1:0]        match_idx, free_idx, use_idx;
  logic                    exec_go;
  logic                    mem_we, mem_re;
  logic [IDX_W-1:0]        mem_addr;
  logic                    tag_we;
  logic [ENTRIES-1:0]      valid_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign exec_go     = (state_q == ST_EXEC) && (!out_valid_q || out_ready_i);

  // Tag compare against every entry, then lowest match and lowest free entry.
  always_comb begin
    match_idx = '0;
    free_idx  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = (tag_q[i] == item_q.port);
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        match_idx = IDX_W'(i);
      end
      if (!valid_q[i]) begin
        free_idx = IDX_W'(i);
      end
    end
    any_match = |match;
    any_free  = ~&valid_q;
  end

  // Command decode for the execute cycle.
  always_comb begin
    status_d  = STAT_OK;
    slot_d    = '0;
    deliver_d = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    tag_we    = 1'b0;
    use_idx   = match_idx;
    valid_d   = valid_q;
    case (item_q.command)
      CMD_LOOKUP: begin
        if (any_match) begin
          slot_d = SLOT_W'(match_idx);
        end
        if (any_match && valid_q[match_idx]) begin
          deliver_d = 1'b1;
          mem_re    = 1'b1;
        end else begin
          status_d = STAT_UNREACH;
        end
      end
      CMD_OPEN: begin
        use_idx = any_match ? match_idx : free_idx;
        if (any_match || any_free) begin
          slot_d           = SLOT_W'(use_idx);
          mem_we           = 1'b1;
          tag_we           = 1'b1;
          valid_d[use_idx] = 1'b1;
        end else begin
          status_d = STAT_FULL;
        end
      end
      CMD_CLOSE: begin
        valid_d = valid_q & ~match;
        if (any_match) begin
          slot_d = SLOT_W'(match_idx);
        end
      end
      default: begin
        status_d = STAT_OK;
      end
    endcase
    mem_addr = use_idx;
  end

  // Sequencer: capture one item, then execute it once the output is free.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_go) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state, tags and valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      valid_q     <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        tag_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (exec_go) begin
        out_valid_q <= 1'b1;
        valid_q     <= valid_d;
        if (tag_we) begin
          tag_q[use_idx] <= item_q.port;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item capture and result payload registers.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_data_i;
    end
    if (exec_go) begin
      status_q  <= status_d;
      slot_q    <= slot_d;
      deliver_q <= deliver_d;
    end
  end

  // Handler RAM: one write or one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (exec_go && mem_we) begin
      hmem[mem_addr] <= item_q.handler_id;
    end
    if (exec_go && mem_re) begin
      rdata_q <= hmem[mem_addr];
    end
  end

  assign out_data_o.status      = status_q;
  assign out_data_o.slot        = slot_q;
  assign out_data_o.handler_out = deliver_q ? rdata_q : '0;

`ifndef NO_ASSERTIONS
  // A nonzero handler is only ever shown on a delivered lookup.
  a_handler_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.handler_out != '0) |-> out_data_o.status == STAT_OK)
    else $error("handler shown on a result that is not a delivery");

  // A full-table result carries neither slot nor handler.
  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == STAT_FULL) |->
      (out_data_o.slot == '0 && out_data_o.handler_out == '0))
    else $error("full result with nonzero slot or handler");

  // One item at a time: in the cycle after an accept the input is closed.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second item accepted while one is in execution");
`endif

endmodule
